@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the interleaver checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HFBI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interleaver check failed");

// Next-cycle implication, disabled while reset is high.
`define HFBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interleaver check failed");

`endif

@@ sv/hfbi_pkg.sv @@
// ----------------------------------------------------------------------------
// hfbi_pkg
// Types and constants of the block bit interleaver.
// ----------------------------------------------------------------------------
`default_nettype none

package hfbi_pkg;

   // Default matrix limits.
   localparam int MAX_ROWS_DEFAULT    = 64;
   localparam int MAX_COLUMNS_DEFAULT = 1024;

   // Register widths.
   localparam int ROW_COUNT_W    = 7;
   localparam int COLUMN_COUNT_W = 11;
   localparam int LOAD_STEP_W    = 6;
   localparam int FETCH_STEP_W   = 10;

   // Register reset values.
   localparam logic [ROW_COUNT_W-1:0]    ROW_COUNT_RESET    = 7'd40;
   localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RESET = 11'd576;
   localparam logic [LOAD_STEP_W-1:0]    LOAD_STEP_RESET    = 6'd7;
   localparam logic [FETCH_STEP_W-1:0]   FETCH_STEP_RESET   = 10'd7;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_ROW_COUNT         = 2'd0,
      CSR_COLUMN_COUNT      = 2'd1,
      CSR_LOAD_ROW_STEP     = 2'd2,
      CSR_FETCH_COLUMN_STEP = 2'd3
   } csr_index_type;

   // Request commands and response status.
   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_FETCH     = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      PHASE_LOAD  = 2'b01,
      PHASE_FETCH = 2'b10
   } phase_type;

endpackage

`default_nettype wire

@@ sv/hfbi_modred.sv @@
// ----------------------------------------------------------------------------
// hfbi_modred
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbi_modred #(
   parameter int DW = 10,
   parameter int VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [VW-1:0] remainder
);

   localparam int NW = $clog2(DW + 1);

   logic [NW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW:0]   shifted;

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

   // The partial remainder stays below the divisor, so one subtract per bit
   // brings it back into range.
   always_comb begin
      shifted = {rem_ff, dvd_ff[DW-1]};
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = NW'(DW);
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - NW'(1);
         dvd_in = dvd_ff << 1;
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = VW'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

endmodule

`default_nettype wire

@@ sv/hf_modem_block_bit_interleaver_top.sv @@
// ----------------------------------------------------------------------------
// hf_modem_block_bit_interleaver_top
// Block bit interleaver: a rows-by-columns bit matrix loaded column-wise with
// a row step and fetched row-wise with a backward column step.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                                          Handshake
//   --------   --------------------------------------------   ------------------------
//   request    start, busy, req_cmd, req_data_bit             taken when start & !busy
//   response   rsp_strobe, rsp_out_bit, rsp_last, rsp_status  registered, no stall
//   registers  psel, penable, pwrite, paddr, pwdata, prdata   APB write, pready high
//
// A request is taken when start is high and busy is low, and its response appears
// on the next cycle, so a new request can be taken every cycle while busy is low;
// the fetched bit is registered out of the single-port memory with the response.
// After reset and after every register write, busy goes high while two bit-serial
// units reduce the steps modulo the counts. The response side cannot stall, and
// the matrix needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hf_modem_block_bit_interleaver_top
   import hfbi_pkg::*;
#(
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic                  req_data_bit,
   // Response channel.
   output logic                  rsp_strobe,
   output logic                  rsp_out_bit,
   output logic                  rsp_last,
   output logic                  rsp_status,
   // Register port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Index widths, count widths (able to hold the limit) and one extra bit
   // for sums that may cross the limit before wrapping.
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CNW   = $clog2(MAX_COLUMNS + 1);
   localparam int RXW   = RNW + 1;
   localparam int CXW   = CNW + 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   // ------------------------------------------------------------------------
   // Configuration registers. Any write restarts the block at the first
   // column of the loading phase; the matrix contents are kept.
   // ------------------------------------------------------------------------
   logic [ROW_COUNT_W-1:0]    row_count_ff;
   logic [COLUMN_COUNT_W-1:0] column_count_ff;
   logic [LOAD_STEP_W-1:0]    load_row_step_ff;
   logic [FETCH_STEP_W-1:0]   fetch_column_step_ff;
   logic                      csr_write;
   csr_index_type             csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff         <= ROW_COUNT_RESET;
         column_count_ff      <= COLUMN_COUNT_RESET;
         load_row_step_ff     <= LOAD_STEP_RESET;
         fetch_column_step_ff <= FETCH_STEP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW_COUNT:         row_count_ff         <= pwdata[ROW_COUNT_W-1:0];
            CSR_COLUMN_COUNT:      column_count_ff      <= pwdata[COLUMN_COUNT_W-1:0];
            CSR_LOAD_ROW_STEP:     load_row_step_ff     <= pwdata[LOAD_STEP_W-1:0];
            CSR_FETCH_COLUMN_STEP: fetch_column_step_ff <= pwdata[FETCH_STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_ROW_COUNT:         prdata = CSR_DATA_W'(row_count_ff);
         CSR_COLUMN_COUNT:      prdata = CSR_DATA_W'(column_count_ff);
         CSR_LOAD_ROW_STEP:     prdata = CSR_DATA_W'(load_row_step_ff);
         CSR_FETCH_COLUMN_STEP: prdata = CSR_DATA_W'(fetch_column_step_ff);
         default:               prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Counts in use: zero acts as one, values above the limit act as the limit.
   // ------------------------------------------------------------------------
   logic [RNW-1:0] rows;
   logic [CNW-1:0] cols;

   always_comb begin
      if (row_count_ff == '0) begin
         rows = RNW'(1);
      end else if (32'(row_count_ff) > 32'(MAX_ROWS)) begin
         rows = RNW'(MAX_ROWS);
      end else begin
         rows = RNW'(row_count_ff);
      end
      if (column_count_ff == '0) begin
         cols = CNW'(1);
      end else if (32'(column_count_ff) > 32'(MAX_COLUMNS)) begin
         cols = CNW'(MAX_COLUMNS);
      end else begin
         cols = CNW'(column_count_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Step reduction. A kick in the cycle after reset or a register write starts
   // both remainder units on the settled register values.
   // ------------------------------------------------------------------------
   logic           kick_ff;
   logic           load_mod_busy;
   logic           fetch_mod_busy;
   logic [RNW-1:0] load_mod_rem;
   logic [CNW-1:0] fetch_mod_rem;
   logic [RW-1:0]  load_step;
   logic [CW-1:0]  fetch_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         kick_ff <= 1'b1;
      end else begin
         kick_ff <= csr_write;
      end
   end

   hfbi_modred #(
      .DW (LOAD_STEP_W),
      .VW (RNW)
   ) u_load_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (kick_ff),
      .dividend  (load_row_step_ff),
      .divisor   (rows),
      .busy      (load_mod_busy),
      .remainder (load_mod_rem)
   );

   hfbi_modred #(
      .DW (FETCH_STEP_W),
      .VW (CNW)
   ) u_fetch_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (kick_ff),
      .dividend  (fetch_column_step_ff),
      .divisor   (cols),
      .busy      (fetch_mod_busy),
      .remainder (fetch_mod_rem)
   );

   // The remainders are below the counts, which never exceed the limits.
   assign load_step  = load_mod_rem[RW-1:0];
   assign fetch_step = fetch_mod_rem[CW-1:0];
   assign busy       = kick_ff | load_mod_busy | fetch_mod_busy;

   // ------------------------------------------------------------------------
   // Cursor state and next-state logic.
   // ------------------------------------------------------------------------
   phase_type     phase_ff, phase_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] pass_ff, pass_in;
   logic [RW-1:0] items_ff, items_in;
   logic          strobe_ff, strobe_in;
   logic          last_ff, last_in;
   logic          status_ff, status_in;
   logic          fetch_ok_ff, fetch_ok_in;

   logic           accept;
   logic           cmd_ok;
   logic           mem_we;
   logic           mem_re;
   logic [RXW-1:0] row_sum;
   logic [RXW-1:0] row_wrap;
   logic [RXW-1:0] items_inc;
   logic [RXW-1:0] row_inc;
   logic [CXW-1:0] col_inc;
   logic [CXW-1:0] pass_inc;
   logic [CW-1:0]  col_back;
   logic           items_full;
   logic           col_full;
   logic           row_done;
   logic           pass_done;

   assign accept = start & ~busy;
   assign cmd_ok = ((req_cmd == CMD_FETCH) == (phase_ff == PHASE_FETCH));

   always_comb begin
      // Loading: the row moves by the reduced step and wraps once at most.
      row_sum    = RXW'(row_ff) + RXW'(load_step);
      row_wrap   = (row_sum >= RXW'(rows)) ? (row_sum - RXW'(rows)) : row_sum;
      items_inc  = RXW'(items_ff) + RXW'(1);
      items_full = (items_inc >= RXW'(rows));
      col_inc    = CXW'(col_ff) + CXW'(1);
      col_full   = (col_inc >= CXW'(cols));
      // Fetching: the row moves down by one, the column back by the step.
      row_inc    = RXW'(row_ff) + RXW'(1);
      row_done   = (row_inc >= RXW'(rows));
      pass_inc   = CXW'(pass_ff) + CXW'(1);
      pass_done  = (pass_inc >= CXW'(cols));
      if (col_ff >= fetch_step) begin
         col_back = col_ff - fetch_step;
      end else begin
         col_back = CW'(CXW'(col_ff) + CXW'(cols) - CXW'(fetch_step));
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pass_in     = pass_ff;
      items_in    = items_ff;
      strobe_in   = accept;
      last_in     = 1'b0;
      status_in   = STATUS_OK;
      fetch_ok_in = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      if (csr_write) begin
         phase_in = PHASE_LOAD;
         row_in   = '0;
         col_in   = '0;
         pass_in  = '0;
         items_in = '0;
      end else if (accept) begin
         if (!cmd_ok) begin
            status_in = STATUS_REJECT;
         end else if (phase_ff == PHASE_LOAD) begin
            mem_we = 1'b1;
            if (items_full) begin
               items_in = '0;
               row_in   = '0;
               if (col_full) begin
                  col_in   = '0;
                  pass_in  = '0;
                  phase_in = PHASE_FETCH;
                  last_in  = 1'b1;
               end else begin
                  col_in = col_inc[CW-1:0];
               end
            end else begin
               items_in = items_inc[RW-1:0];
               row_in   = row_wrap[RW-1:0];
            end
         end else begin
            mem_re      = 1'b1;
            fetch_ok_in = 1'b1;
            if (row_done) begin
               row_in = '0;
               if (pass_done) begin
                  // Last bit of the block: back to loading from the start.
                  last_in  = 1'b1;
                  phase_in = PHASE_LOAD;
                  col_in   = '0;
                  pass_in  = '0;
                  items_in = '0;
               end else begin
                  pass_in = pass_inc[CW-1:0];
                  col_in  = pass_inc[CW-1:0];
               end
            end else begin
               row_in = row_inc[RW-1:0];
               col_in = col_back;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_LOAD;
         row_ff      <= '0;
         col_ff      <= '0;
         pass_ff     <= '0;
         items_ff    <= '0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
         status_ff   <= STATUS_OK;
         fetch_ok_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         pass_ff     <= pass_in;
         items_ff    <= items_in;
         strobe_ff   <= strobe_in;
         last_ff     <= last_in;
         status_ff   <= status_in;
         fetch_ok_ff <= fetch_ok_in;
      end
   end

   // ------------------------------------------------------------------------
   // Matrix memory, one bit per entry, row-major. Loads and fetches never
   // share a cycle, and a fetch of a just-loaded cell comes in a later cycle,
   // so the write is always visible to the read without forwarding.
   // ------------------------------------------------------------------------
   logic          matrix_mem [DEPTH];
   logic [AW-1:0] mem_addr;
   logic          rd_ff;

   assign mem_addr = AW'(row_ff) * AW'(MAX_COLUMNS) + AW'(col_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_mem[mem_addr] <= req_data_bit;
      end
      if (mem_re) begin
         rd_ff <= matrix_mem[mem_addr];
      end
   end

   // The read bit only counts on an accepted fetch; otherwise the bit is zero.
   assign rsp_strobe  = strobe_ff;
   assign rsp_out_bit = rd_ff & fetch_ok_ff;
   assign rsp_last    = last_ff;
   assign rsp_status  = status_ff;

endmodule

`default_nettype wire

@@ sv/hfbi_checker.sv @@
// ----------------------------------------------------------------------------
// hfbi_checker
// Port-level checks of the interleaver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hfbi_checker
   import hfbi_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic pready,
   input wire logic rsp_strobe,
   input wire logic rsp_out_bit,
   input wire logic rsp_last,
   input wire logic rsp_status
);

   // Every taken request gives exactly one response on the following cycle.
   `HFBI_ASSERT_NEXT(a_response_follows_request, clock, reset, start && !busy, rsp_strobe)
   `HFBI_ASSERT_IMPL(a_response_has_request, clock, reset, rsp_strobe, $past(start && !busy))

   // Response fields are quiet between responses.
   `HFBI_ASSERT_IMPL(a_quiet_between, clock, reset, !rsp_strobe, !rsp_out_bit && !rsp_last && !rsp_status)

   // A rejected request neither returns a bit nor ends a block.
   `HFBI_ASSERT_IMPL(a_reject_clean, clock, reset, rsp_status == STATUS_REJECT, !rsp_out_bit && !rsp_last)

   // A register write holds off requests while the steps are reduced.
   `HFBI_ASSERT_NEXT(a_write_holds_off, clock, reset, psel && penable && pwrite && pready, busy)

endmodule

bind hf_modem_block_bit_interleaver_top hfbi_checker u_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block bit interleaver. A generator fills a
// queue of load and fetch requests and rewrites the geometry registers
// between blocks, a clocked driver presents the requests with random gaps,
// and a clocked monitor checks every response against a bit-accurate
// software matrix kept alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hfbi_pkg::*;

   localparam int ROWS_LIMIT    = MAX_ROWS_DEFAULT;
   localparam int COLUMNS_LIMIT = MAX_COLUMNS_DEFAULT;
   localparam int IDLE_PERCENT  = 37;     // chance of a gap in front of a request
   localparam int STALL_LIMIT   = 2000;   // cycles without any handshake
   localparam int RANDOM_ITEMS  = 1050;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 4;      // margin after the last response

   // How a block of requests ends: complete, cut during loading, or cut during
   // fetching. A cut block is followed by a register write unless it ends the run.
   typedef enum {WHOLE, CUT_LOAD, CUT_FETCH} block_end_type;

   typedef struct packed {
      logic cmd;
      logic data_bit;
   } request_type;

   typedef struct packed {
      logic out_bit;
      logic last;
      logic status;
   } response_type;

   // Block ports. Every input starts at a known value.
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic                  busy;
   logic                  req_cmd      = CMD_LOAD;
   logic                  req_data_bit = 1'b0;
   logic                  rsp_strobe;
   logic                  rsp_out_bit;
   logic                  rsp_last;
   logic                  rsp_status;
   logic                  psel         = 1'b0;
   logic                  penable      = 1'b0;
   logic                  pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr        = '0;
   logic [CSR_DATA_W-1:0] pwdata       = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Register copies, as written through the register port.
   logic [ROW_COUNT_W-1:0]    cfg_rows       = ROW_COUNT_RESET;
   logic [COLUMN_COUNT_W-1:0] cfg_cols       = COLUMN_COUNT_RESET;
   logic [LOAD_STEP_W-1:0]    cfg_load_step  = LOAD_STEP_RESET;
   logic [FETCH_STEP_W-1:0]   cfg_fetch_step = FETCH_STEP_RESET;

   // Software copy of the matrix and of the block's cursors.
   bit [COLUMNS_LIMIT-1:0] cell_bits [ROWS_LIMIT];
   phase_type              stage       = PHASE_LOAD;
   int unsigned            cur_row     = 0;
   int unsigned            cur_col     = 0;
   int unsigned            pass_origin = 0;
   int unsigned            column_fill = 0;

   // Cells known to hold a loaded bit. Fetches are only planned over a region
   // that is fully covered, since the matrix powers up undefined.
   bit [COLUMNS_LIMIT-1:0] cell_loaded [ROWS_LIMIT];

   request_type  pending_req_q [$];
   response_type expected_rsp_q [$];
   bit           steady         = 1'b0;
   int unsigned  issued         = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  stall_cycles   = 0;

   hf_modem_block_bit_interleaver_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_data_bit (req_data_bit),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_bit  (rsp_out_bit),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // A zero count behaves as one, and counts past the matrix size saturate.
   function automatic int unsigned active_rows();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > ROWS_LIMIT) return ROWS_LIMIT;
      return cfg_rows;
   endfunction

   function automatic int unsigned active_columns();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > COLUMNS_LIMIT) return COLUMNS_LIMIT;
      return cfg_cols;
   endfunction

   // Any register write abandons the current block; the matrix is kept.
   function automatic void rewind_cursors();
      stage       = PHASE_LOAD;
      cur_row     = 0;
      cur_col     = 0;
      pass_origin = 0;
      column_fill = 0;
   endfunction

   // Applies one accepted request to the software matrix and queues the
   // response the block owes for it.
   function automatic void predict_response(input request_type req);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  r;
      int unsigned  c;
      response_type rsp;
      rows = active_rows();
      cols = active_columns();
      r    = cur_row % rows;
      c    = cur_col % cols;
      rsp  = '{out_bit: 1'b0, last: 1'b0, status: STATUS_OK};
      if ((req.cmd == CMD_FETCH) != (stage == PHASE_FETCH)) begin
         // Out of phase: rejected, nothing moves.
         rsp.status = STATUS_REJECT;
      end else if (req.cmd == CMD_LOAD) begin
         cell_bits[r][c] = req.data_bit;
         cur_row = (r + cfg_load_step % rows) % rows;
         column_fill++;
         if (column_fill >= rows) begin
            // Column complete: next column starts again at row zero.
            column_fill = 0;
            cur_row     = 0;
            c++;
            if (c >= cols) begin
               c           = 0;
               stage       = PHASE_FETCH;
               pass_origin = 0;
               rsp.last    = 1'b1;
            end
         end
         cur_col = c;
      end else begin
         rsp.out_bit = cell_bits[r][c];
         r++;
         c = (c + cols - cfg_fetch_step % cols) % cols;
         if (r >= rows) begin
            // Pass complete: the next one starts a column to the right.
            r           = 0;
            pass_origin = pass_origin % cols + 1;
            if (pass_origin >= cols) begin
               rsp.last = 1'b1;
               rewind_cursors();
               c = 0;
            end else begin
               c = pass_origin;
            end
         end
         cur_row = r;
         cur_col = c;
      end
      expected_rsp_q.push_back(rsp);
   endfunction

   function automatic void note_mismatch(input string what,
                                         input logic [CSR_DATA_W-1:0] want,
                                         input logic [CSR_DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: a request is taken when start is high and busy is low. The next
   // request from the queue goes out at the same edge, unless a random gap is
   // drawn. While busy is high the current request is held unchanged.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      request_type item;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_response('{cmd: req_cmd, data_bit: req_data_bit});
         end
         if (!start || !busy) begin
            if (pending_req_q.size() > 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               item          = pending_req_q.pop_front();
               start        <= 1'b1;
               req_cmd      <= item.cmd;
               req_data_bit <= item.data_bit;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: each strobe carries one response, checked field by field
   // against the oldest open prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      response_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            note_mismatch("response with nothing outstanding", '0,
                          CSR_DATA_W'({rsp_out_bit, rsp_last, rsp_status}));
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_out_bit !== want.out_bit) begin
               note_mismatch("out_bit", CSR_DATA_W'(want.out_bit), CSR_DATA_W'(rsp_out_bit));
            end
            if (rsp_last !== want.last) begin
               note_mismatch("last", CSR_DATA_W'(want.last), CSR_DATA_W'(rsp_last));
            end
            if (rsp_status !== want.status) begin
               note_mismatch("status", CSR_DATA_W'(want.status), CSR_DATA_W'(rsp_status));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any handshake on any channel restarts the count.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("hf_modem_block_bit_interleaver_top test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Generator
   // ------------------------------------------------------------------------

   // Returns at a rising edge once no request is queued or presented and every
   // predicted response has been seen. Each request yields exactly one
   // response, so the block itself is idle too.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0);
      @(posedge clock);
   endtask

   // One register transfer: setup cycle, then access until pready. A write
   // updates the register copies and rewinds the cursors at the edge that
   // commits it; a read is compared with the register copy.
   task automatic csr_access(input logic is_write, input csr_index_type index,
                             input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] held;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (pready !== 1'b1);
      if (is_write) begin
         case (index)
            CSR_ROW_COUNT:         cfg_rows       = value[ROW_COUNT_W-1:0];
            CSR_COLUMN_COUNT:      cfg_cols       = value[COLUMN_COUNT_W-1:0];
            CSR_LOAD_ROW_STEP:     cfg_load_step  = value[LOAD_STEP_W-1:0];
            CSR_FETCH_COLUMN_STEP: cfg_fetch_step = value[FETCH_STEP_W-1:0];
            default: begin
            end
         endcase
         rewind_cursors();
      end else begin
         case (index)
            CSR_ROW_COUNT:         held = CSR_DATA_W'(cfg_rows);
            CSR_COLUMN_COUNT:      held = CSR_DATA_W'(cfg_cols);
            CSR_LOAD_ROW_STEP:     held = CSR_DATA_W'(cfg_load_step);
            CSR_FETCH_COLUMN_STEP: held = CSR_DATA_W'(cfg_fetch_step);
            default:               held = '0;
         endcase
         if (prdata !== held) note_mismatch("register readback", held, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Rewrites all four registers with junk above each field, then reads
   // them back. Only done with the block idle.
   task automatic configure(input int unsigned rows_v, input int unsigned cols_v,
                            input int unsigned load_step_v, input int unsigned fetch_step_v);
      wait_idle();
      csr_access(1'b1, CSR_ROW_COUNT,
                 (CSR_DATA_W'($urandom) << ROW_COUNT_W) | CSR_DATA_W'(rows_v));
      csr_access(1'b1, CSR_COLUMN_COUNT,
                 (CSR_DATA_W'($urandom) << COLUMN_COUNT_W) | CSR_DATA_W'(cols_v));
      csr_access(1'b1, CSR_LOAD_ROW_STEP,
                 (CSR_DATA_W'($urandom) << LOAD_STEP_W) | CSR_DATA_W'(load_step_v));
      csr_access(1'b1, CSR_FETCH_COLUMN_STEP,
                 (CSR_DATA_W'($urandom) << FETCH_STEP_W) | CSR_DATA_W'(fetch_step_v));
      csr_access(1'b0, CSR_ROW_COUNT, '0);
      csr_access(1'b0, CSR_COLUMN_COUNT, '0);
      csr_access(1'b0, CSR_LOAD_ROW_STEP, '0);
      csr_access(1'b0, CSR_FETCH_COLUMN_STEP, '0);
   endtask

   // Queues count well-formed requests of one command with random data. Out of
   // phase requests are sprinkled in front of them; those only get rejected
   // and are not counted.
   task automatic queue_requests(input logic cmd, input int unsigned count,
                                 input int unsigned noise_pct);
      request_type item;
      @(negedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            item.cmd      = ~cmd;
            item.data_bit = 1'($urandom_range(1));
            pending_req_q.push_back(item);
         end
         item.cmd      = cmd;
         item.data_bit = 1'($urandom_range(1));
         pending_req_q.push_back(item);
         issued++;
      end
   endtask

   // Programs a geometry and runs one or more blocks through it. When the load
   // step shares a factor with the row count, part of the matrix is never
   // loaded; if that region has not been covered before, it is first filled
   // with a step of one so that no fetch reads an undefined cell.
   task automatic run_block(input int unsigned rows_v, input int unsigned cols_v,
                            input int unsigned load_step_v, input int unsigned fetch_step_v,
                            input int unsigned blocks, input block_end_type ending,
                            input bit pause, input bit no_gaps);
      int unsigned n_rows;
      int unsigned n_cols;
      int unsigned cells;
      int unsigned a;
      int unsigned b;
      int unsigned t;
      int unsigned noise;
      bit          covered;
      configure(rows_v, cols_v, load_step_v, fetch_step_v);
      steady = no_gaps;
      noise  = $urandom_range(15);
      n_rows = active_rows();
      n_cols = active_columns();
      cells  = n_rows * n_cols;
      a = cfg_load_step % n_rows;
      b = n_rows;
      while (a != 0) begin
         t = b % a;
         b = a;
         a = t;
      end
      covered = (b == 1);
      if (!covered && ending != CUT_LOAD) begin
         covered = 1'b1;
         for (int r = 0; r < n_rows; r++) begin
            for (int c = 0; c < n_cols; c++) begin
               if (!cell_loaded[r][c]) covered = 1'b0;
            end
         end
         if (!covered) begin
            configure(rows_v, cols_v, 1, fetch_step_v);
            queue_requests(CMD_LOAD, cells, 0);
            configure(rows_v, cols_v, load_step_v, fetch_step_v);
            covered = 1'b1;
         end
      end
      if (covered && ending != CUT_LOAD) begin
         for (int r = 0; r < n_rows; r++) begin
            for (int c = 0; c < n_cols; c++) begin
               cell_loaded[r][c] = 1'b1;
            end
         end
      end
      for (int k = 0; k < blocks; k++) begin
         if (ending == CUT_LOAD) begin
            queue_requests(CMD_LOAD, $urandom_range(cells - 1, 0), noise);
         end else begin
            queue_requests(CMD_LOAD, cells, noise);
            // Hold the next request back until the matrix is full and every
            // response is in.
            if (pause) wait_idle();
            queue_requests(CMD_FETCH,
                           (ending == CUT_FETCH) ? $urandom_range(cells - 1, 0) : cells,
                           noise);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned   rows_v;
      int unsigned   cols_v;
      int unsigned   pick;
      block_end_type ending;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Power-on geometry: a few loads and an out of phase fetch, then the
      // register writes below abandon the partly loaded block.
      @(negedge clock);
      pending_req_q.push_back('{CMD_LOAD, 1'b1});
      pending_req_q.push_back('{CMD_LOAD, 1'b0});
      pending_req_q.push_back('{CMD_FETCH, 1'b1});
      pending_req_q.push_back('{CMD_LOAD, 1'b1});

      // Single cell: one load fills the matrix, one fetch empties it, and a
      // request of the wrong kind is rejected on either side.
      configure(1, 1, 0, 0);
      @(negedge clock);
      pending_req_q.push_back('{CMD_LOAD, 1'b1});
      pending_req_q.push_back('{CMD_LOAD, 1'b0});
      pending_req_q.push_back('{CMD_FETCH, 1'b0});
      pending_req_q.push_back('{CMD_FETCH, 1'b1});

      // Zero counts act as one row and one column; both steps reduce to zero.
      configure(0, 0, 63, 1023);
      @(negedge clock);
      pending_req_q.push_back('{CMD_LOAD, 1'b0});
      pending_req_q.push_back('{CMD_FETCH, 1'b1});

      // Small block with the sender held off between loading and fetching.
      run_block(2, 3, 1, 2, 1, WHOLE, 1'b1, 1'b0);

      // Field extremes: all rows with a step one short of the count and no
      // gaps at all, then rows saturating with an even step.
      run_block(64, 2, 63, 1, 1, WHOLE, 1'b0, 1'b1);
      run_block(127, 1, 62, 1023, 1, WHOLE, 1'b0, 1'b0);

      // Random geometries, mostly small, now and then tall or wide, until the
      // request budget is used up.
      while (issued < RANDOM_ITEMS) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            rows_v = $urandom_range(127, 0);
            cols_v = $urandom_range(3, 0);
         end else if (pick == 1) begin
            rows_v = $urandom_range(3, 0);
            cols_v = $urandom_range(150, 0);
         end else begin
            rows_v = $urandom_range(8, 0);
            cols_v = $urandom_range(10, 0);
         end
         pick = $urandom_range(99);
         ending = (pick < 70) ? WHOLE : (pick < 85) ? CUT_LOAD : CUT_FETCH;
         run_block(rows_v, cols_v,
                   $urandom_range(1) ? $urandom_range(63, 0) : $urandom_range(7, 0),
                   $urandom_range(1) ? $urandom_range(1023, 0) : $urandom_range(10, 0),
                   (ending == WHOLE && $urandom_range(3) == 0) ? 2 : 1,
                   ending, $urandom_range(3) == 0, $urandom_range(4) == 0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("hf_modem_block_bit_interleaver_top test passed");
      end else begin
         $display("hf_modem_block_bit_interleaver_top test failed");
      end
      $finish;
   end

endmodule
